// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define KVT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kvt assertion failed");

// Checked on every rising edge, reset included.
`define KVT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("kvt assertion failed");

`endif

// ===== hdl/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// Types, codes and character constants for the key-value text tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  localparam int unsigned MAX_RES = 4;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_UNQ     = 3'd3,
    MODE_UNQ_ESC = 3'd4,
    MODE_QUO     = 3'd5,
    MODE_QUO_ESC = 3'd6,
    MODE_DONE    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_BEGIN = 3'd2,
    KIND_CHAR  = 3'd3,
    KIND_END   = 3'd4,
    KIND_EOS   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic       is_quoted;
    logic       last;
  } res_t;

  // Results of one input byte, in emission order, with their count (0 to 4).
  typedef struct packed {
    logic [2:0]             cnt;
    res_t [MAX_RES-1:0]     ent;
  } grp_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] c, logic q);
    res_t r;
    r.kind       = k;
    r.char_value = c;
    r.is_quoted  = q;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kvt_decode.sv =====
// ----------------------------------------------------------------------------
// kvt_decode
// Lexer step: one byte and the current mode give the result group and the
// next mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvt_decode (
  input  kvt_pkg::mode_t    mode,
  input  kvt_pkg::in_item_t item,
  output kvt_pkg::grp_t     grp,
  output kvt_pkg::mode_t    mode_nxt
);

  logic [7:0]          b;
  logic                fin;
  logic                do_unq;
  logic                esc;
  logic                is_ws;
  logic                is_nl;
  logic [2:0]          n;
  kvt_pkg::res_t [3:0] res;

  assign b     = item.in_byte;
  assign fin   = item.end_of_input || (b == kvt_pkg::CH_NUL);
  assign is_nl = (b == kvt_pkg::CH_LF) || (b == kvt_pkg::CH_CR);
  assign is_ws = is_nl || (b == kvt_pkg::CH_SPACE) || (b == kvt_pkg::CH_TAB);

  always_comb begin
    res      = '0;
    n        = 3'd0;
    mode_nxt = mode;
    do_unq   = 1'b0;
    esc      = 1'b0;

    unique case (mode)
      kvt_pkg::MODE_START: begin
        priority if (fin) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_EOS, 8'h00, 1'b0);
          n = n + 3'd1;
          mode_nxt = kvt_pkg::MODE_DONE;
        end else if (is_ws) begin
          mode_nxt = kvt_pkg::MODE_START;
        end else if (b == kvt_pkg::CH_SLASH) begin
          mode_nxt = kvt_pkg::MODE_SLASH;
        end else if (b == kvt_pkg::CH_LBRACE) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_OPEN, 8'h00, 1'b0);
          n = n + 3'd1;
        end else if (b == kvt_pkg::CH_RBRACE) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_CLOSE, 8'h00, 1'b0);
          n = n + 3'd1;
        end else if (b == kvt_pkg::CH_QUOTE) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_BEGIN, 8'h00, 1'b1);
          n = n + 3'd1;
          mode_nxt = kvt_pkg::MODE_QUO;
        end else begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_BEGIN, 8'h00, 1'b0);
          n = n + 3'd1;
          do_unq = 1'b1;
        end
      end
      kvt_pkg::MODE_SLASH: begin
        if (!fin && (b == kvt_pkg::CH_SLASH)) begin
          mode_nxt = kvt_pkg::MODE_COMMENT;
        end else begin
          // A lone slash opens an unquoted string; the byte is then handled in it.
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_BEGIN, 8'h00, 1'b0);
          n = n + 3'd1;
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_CHAR, kvt_pkg::CH_SLASH, 1'b0);
          n = n + 3'd1;
          do_unq = 1'b1;
        end
      end
      kvt_pkg::MODE_COMMENT: begin
        priority if (fin) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_EOS, 8'h00, 1'b0);
          n = n + 3'd1;
          mode_nxt = kvt_pkg::MODE_DONE;
        end else if (b == kvt_pkg::CH_LF) begin
          mode_nxt = kvt_pkg::MODE_START;
        end else begin
          mode_nxt = kvt_pkg::MODE_COMMENT;
        end
      end
      kvt_pkg::MODE_UNQ, kvt_pkg::MODE_UNQ_ESC: begin
        do_unq = 1'b1;
        esc    = (mode == kvt_pkg::MODE_UNQ_ESC);
      end
      kvt_pkg::MODE_QUO, kvt_pkg::MODE_QUO_ESC: begin
        priority if (fin) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_END, 8'h00, 1'b0);
          n = n + 3'd1;
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_EOS, 8'h00, 1'b0);
          n = n + 3'd1;
          mode_nxt = kvt_pkg::MODE_DONE;
        end else if (mode == kvt_pkg::MODE_QUO_ESC) begin
          mode_nxt = kvt_pkg::MODE_QUO;
          if ((b == kvt_pkg::CH_QUOTE) || (b == kvt_pkg::CH_BSLASH)) begin
            res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_CHAR, b, 1'b0);
            n = n + 3'd1;
          end
        end else if (b == kvt_pkg::CH_QUOTE) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_END, 8'h00, 1'b0);
          n = n + 3'd1;
          mode_nxt = kvt_pkg::MODE_START;
        end else if (b == kvt_pkg::CH_BSLASH) begin
          mode_nxt = kvt_pkg::MODE_QUO_ESC;
        end else if (!is_nl) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_CHAR, b, 1'b0);
          n = n + 3'd1;
          mode_nxt = kvt_pkg::MODE_QUO;
        end else begin
          mode_nxt = kvt_pkg::MODE_QUO;
        end
      end
      default: begin
        mode_nxt = kvt_pkg::MODE_DONE;
      end
    endcase

    // Shared handling of a byte inside an unquoted string.
    if (do_unq) begin
      priority if (fin) begin
        res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_END, 8'h00, 1'b0);
        n = n + 3'd1;
        res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_EOS, 8'h00, 1'b0);
        n = n + 3'd1;
        mode_nxt = kvt_pkg::MODE_DONE;
      end else if ((b == kvt_pkg::CH_LBRACE) || (b == kvt_pkg::CH_RBRACE)) begin
        res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_END, 8'h00, 1'b0);
        n = n + 3'd1;
        res[n[1:0]] = kvt_pkg::mk_res((b == kvt_pkg::CH_LBRACE) ? kvt_pkg::KIND_OPEN
                                                                 : kvt_pkg::KIND_CLOSE,
                                      8'h00, 1'b0);
        n = n + 3'd1;
        mode_nxt = kvt_pkg::MODE_START;
      end else if (esc) begin
        mode_nxt = kvt_pkg::MODE_UNQ;
        if ((b == kvt_pkg::CH_QUOTE) || (b == kvt_pkg::CH_BSLASH)) begin
          res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_CHAR, b, 1'b0);
          n = n + 3'd1;
        end
      end else if (b == kvt_pkg::CH_BSLASH) begin
        mode_nxt = kvt_pkg::MODE_UNQ_ESC;
      end else if (!is_nl) begin
        res[n[1:0]] = kvt_pkg::mk_res(kvt_pkg::KIND_CHAR, b, 1'b0);
        n = n + 3'd1;
        mode_nxt = kvt_pkg::MODE_UNQ;
      end else begin
        mode_nxt = kvt_pkg::MODE_UNQ;
      end
    end

    // A count of four wraps the index to zero, so minus one lands on entry three.
    if (n != 3'd0) begin
      res[n[1:0] - 2'd1].last = 1'b1;
    end
  end

  assign grp.cnt = n;
  assign grp.ent = res;

endmodule

`default_nettype wire

// ===== hdl/kvt_result_buf.sv =====
// ----------------------------------------------------------------------------
// kvt_result_buf
// Result register: holds one group of up to four results and hands them out
// one beat at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvt_result_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  kvt_pkg::grp_t  grp,
  output logic           grp_free,
  output logic           out_valid,
  input  logic           out_ready,
  output kvt_pkg::res_t  out_data
);

  logic [2:0]          rem_r;
  logic [2:0]          rem_nxt;
  kvt_pkg::res_t [3:0] ent_r;
  kvt_pkg::res_t [3:0] ent_nxt;
  logic                fire;

  assign out_valid = (rem_r != 3'd0);
  assign out_data  = ent_r[0];
  assign fire      = out_valid && out_ready;
  // The group may be replaced once its final beat goes out in this cycle.
  assign grp_free  = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_ready);

  always_comb begin
    rem_nxt = rem_r;
    ent_nxt = ent_r;
    if (fire) begin
      rem_nxt    = rem_r - 3'd1;
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      ent_nxt[2] = ent_r[3];
    end
    if (load) begin
      rem_nxt = grp.cnt;
      ent_nxt = grp.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/keyvalues_text_tokenizer_unit.sv =====
// An accepted byte is registered, decoded and loaded into the result register once
// that register is free; its first result beat, if any, is offered from then on.
// Throughput: one byte per cycle while out_ready is high and each byte yields at
// most one result; a byte with more (up to four) holds the register until all are taken.
// Reset (synchronous, rst_n low) returns the lexer to token start and empties both
// the input register and the result register.
// ----------------------------------------------------------------------------
// keyvalues_text_tokenizer_unit
// Key-value text tokenizer top level: input register, lexer step and mode
// register, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyvalues_text_tokenizer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kvt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kvt_pkg::res_t     out_data
);

  logic              in_v_r;
  logic              in_v_nxt;
  kvt_pkg::in_item_t in_d_r;
  kvt_pkg::mode_t    mode_r;
  kvt_pkg::mode_t    mode_nxt;
  kvt_pkg::mode_t    dec_mode;
  kvt_pkg::grp_t     dec_grp;
  logic              grp_free;
  logic              load;
  logic              in_fire;

  assign load     = in_v_r && grp_free;
  assign in_ready = !in_v_r || grp_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (load) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    if (load) begin
      mode_nxt = dec_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      mode_r <= kvt_pkg::MODE_START;
    end else begin
      in_v_r <= in_v_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_d_r <= in_data;
    end
  end

  kvt_decode u_decode (
    .mode     (mode_r),
    .item     (in_d_r),
    .grp      (dec_grp),
    .mode_nxt (dec_mode)
  );

  kvt_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp       (dec_grp),
    .grp_free  (grp_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/kvt_checker.sv =====
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks on the tokenizer's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kvt_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire kvt_pkg::res_t     out_data
);

  logic out_is_char;
  logic out_is_begin;
  logic out_is_eos;

  assign out_is_char  = out_valid && (out_data.kind == kvt_pkg::KIND_CHAR);
  assign out_is_begin = out_valid && (out_data.kind == kvt_pkg::KIND_BEGIN);
  assign out_is_eos   = out_valid && (out_data.kind == kvt_pkg::KIND_EOS);

  `KVT_ASSERT_ALWAYS(a_empty_after_reset, $past(!rst_n) |-> !out_valid)
  `KVT_ASSERT(a_hold_on_stall, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
  `KVT_ASSERT(a_char_only_for_char, (out_valid && !out_is_char) |-> (out_data.char_value == 8'h00))
  `KVT_ASSERT(a_quote_only_on_begin, (out_valid && !out_is_begin) |-> !out_data.is_quoted)
  `KVT_ASSERT(a_eos_is_last, out_is_eos |-> out_data.last)
  // With no beat waiting the result register is free, so the input must be open.
  `KVT_ASSERT(a_ready_when_idle, !out_valid |-> in_ready)

endmodule

bind keyvalues_text_tokenizer_unit kvt_checker u_kvt_checker (.*);

`default_nettype wire
